/* hdl/srdb_pkg.sv */
`default_nettype none

package srdb_pkg;

    // Default field widths: Q1.15 samples and twiddles.
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int TWIDDLE_BITS_DEF = 16;

    // Register stages from the input transfer to the output register.
    localparam int SRDB_STAGES = 5;

endpackage

`default_nettype wire

/* hdl/split_radix_dif_butterfly_top.sv */
// Throughput: one butterfly per clock cycle while i_m_tready is high; the five register
// stages each take a new item whenever they are empty or their content moves on.
// Reset: synchronous, active low; it clears the stage valid bits only, so the pipeline
// comes out of reset empty and ready.
`default_nettype none

module split_radix_dif_butterfly_top
    import srdb_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF,
    localparam int IN_W        = 8 * SAMPLE_BITS + 4 * TWIDDLE_BITS,
    localparam int IN_TW       = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = 8 * (SAMPLE_BITS + 2)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Slave side. tdata from bit 0 up: x0_re, x0_im, x1_re, x1_im, x2_re, x2_im,
    // x3_re, x3_im (SAMPLE_BITS each), then w1_re, w1_im, w3_re, w3_im
    // (TWIDDLE_BITS each), zero filled to whole bytes.
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [IN_TW-1:0] i_s_tdata,
    // Master side. tdata from bit 0 up: y0_re, y0_im, y1_re, y1_im, y2_re, y2_im,
    // y3_re, y3_im, each SAMPLE_BITS+2 bits wide.
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [OUT_W-1:0]      o_m_tdata
);

    // Widths along the datapath.
    localparam int SW   = SAMPLE_BITS;
    localparam int TW   = TWIDDLE_BITS;
    localparam int OW   = SW + 2;      // outputs and plain sums
    localparam int DW   = SW + 1;      // a and b components
    localparam int CW   = SW + 2;      // a -/+ j*b components
    localparam int PW   = CW + TW;     // one partial product
    localparam int SUMW = PW + 1;      // product sum plus rounding constant
    localparam int SHW  = SUMW - TW + 1;

    localparam logic signed [SUMW-1:0] RND = SUMW'(1) << (TW - 2);
    localparam logic signed [OW-1:0]   SAT_MAX = {1'b0, {(OW - 1){1'b1}}};
    localparam logic signed [OW-1:0]   SAT_MIN = {1'b1, {(OW - 1){1'b0}}};

    // Flow control. A stage may load when it is empty or when its content moves on
    // in the same cycle, so bubbles are squeezed out even while the output stalls.
    logic [SRDB_STAGES-1:0] r_vld;
    logic [SRDB_STAGES-1:0] ce;

    always_comb begin
        ce[SRDB_STAGES-1] = !r_vld[SRDB_STAGES-1] || i_m_tready;
        for (int k = SRDB_STAGES - 2; k >= 0; k--) begin
            ce[k] = !r_vld[k] || ce[k+1];
        end
    end

    assign o_s_tready = ce[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ce[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < SRDB_STAGES; k++) begin
                if (ce[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Input unpacking: eight sample components, then four twiddle components.
    logic signed [SW-1:0] x [8];
    logic signed [TW-1:0] w [4];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            x[i] = i_s_tdata[i*SW +: SW];
        end
        for (int j = 0; j < 4; j++) begin
            w[j] = i_s_tdata[8*SW + j*TW +: TW];
        end
    end

    // Stage 1: the plain sums y0, y1 and the differences a, b.
    logic signed [OW-1:0] n_s1_y [4];
    logic signed [DW-1:0] n_s1_d [4];
    logic signed [OW-1:0] r_s1_y [4];
    logic signed [DW-1:0] r_s1_d [4];
    logic signed [TW-1:0] r_s1_w [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_s1_y[i] = {{2{x[i][SW-1]}}, x[i]} + {{2{x[i+4][SW-1]}}, x[i+4]};
            n_s1_d[i] = {x[i][SW-1], x[i]} - {x[i+4][SW-1], x[i+4]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[0]) begin
            r_s1_y <= n_s1_y;
            r_s1_d <= n_s1_d;
            r_s1_w <= w;
        end
    end

    // Stage 2: a - j*b = (ar + bi) + j(ai - br), a + j*b = (ar - bi) + j(ai + br).
    // The d entries hold ar, ai, br, bi in that order.
    logic signed [CW-1:0] n_s2_c [4];
    logic signed [CW-1:0] r_s2_c [4];
    logic signed [OW-1:0] r_s2_y [4];
    logic signed [TW-1:0] r_s2_w [4];

    always_comb begin
        n_s2_c[0] = {r_s1_d[0][DW-1], r_s1_d[0]} + {r_s1_d[3][DW-1], r_s1_d[3]};
        n_s2_c[1] = {r_s1_d[1][DW-1], r_s1_d[1]} - {r_s1_d[2][DW-1], r_s1_d[2]};
        n_s2_c[2] = {r_s1_d[0][DW-1], r_s1_d[0]} - {r_s1_d[3][DW-1], r_s1_d[3]};
        n_s2_c[3] = {r_s1_d[1][DW-1], r_s1_d[1]} + {r_s1_d[2][DW-1], r_s1_d[2]};
    end

    always_ff @(posedge i_clk) begin
        if (ce[1]) begin
            r_s2_c <= n_s2_c;
            r_s2_y <= r_s1_y;
            r_s2_w <= r_s1_w;
        end
    end

    // Stage 3: the eight real products of the two complex multiplies.
    logic signed [PW-1:0] n_s3_p [8];
    logic signed [PW-1:0] r_s3_p [8];
    logic signed [OW-1:0] r_s3_y [4];

    always_comb begin
        for (int h = 0; h < 2; h++) begin
            n_s3_p[4*h]     = r_s2_c[2*h]     * r_s2_w[2*h];
            n_s3_p[4*h + 1] = r_s2_c[2*h + 1] * r_s2_w[2*h + 1];
            n_s3_p[4*h + 2] = r_s2_c[2*h]     * r_s2_w[2*h + 1];
            n_s3_p[4*h + 3] = r_s2_c[2*h + 1] * r_s2_w[2*h];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[2]) begin
            r_s3_p <= n_s3_p;
            r_s3_y <= r_s2_y;
        end
    end

    // Stage 4: combine the products and add the half-LSB rounding constant.
    logic signed [SUMW-1:0] n_s4_s [4];
    logic signed [SUMW-1:0] r_s4_s [4];
    logic signed [OW-1:0]   r_s4_y [4];

    always_comb begin
        for (int h = 0; h < 2; h++) begin
            n_s4_s[2*h] = {r_s3_p[4*h][PW-1], r_s3_p[4*h]}
                        - {r_s3_p[4*h + 1][PW-1], r_s3_p[4*h + 1]} + RND;
            n_s4_s[2*h + 1] = {r_s3_p[4*h + 2][PW-1], r_s3_p[4*h + 2]}
                            + {r_s3_p[4*h + 3][PW-1], r_s3_p[4*h + 3]} + RND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[3]) begin
            r_s4_s <= n_s4_s;
            r_s4_y <= r_s3_y;
        end
    end

    // Stage 5: drop the fraction bits and clamp to the output range. The shifted
    // value fits the output when its bits above the output sign all equal that sign.
    logic signed [SHW-1:0] sh [4];
    logic signed [OW-1:0]  n_s5_z [4];
    logic signed [OW-1:0]  r_s5_z [4];
    logic signed [OW-1:0]  r_s5_y [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sh[i] = r_s4_s[i][SUMW-1:TW-1];
            if (sh[i][SHW-1:OW-1] == '0 || sh[i][SHW-1:OW-1] == '1) begin
                n_s5_z[i] = sh[i][OW-1:0];
            end else if (sh[i][SHW-1]) begin
                n_s5_z[i] = SAT_MIN;
            end else begin
                n_s5_z[i] = SAT_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[4]) begin
            r_s5_z <= n_s5_z;
            r_s5_y <= r_s4_y;
        end
    end

    // Output register drives the master side directly.
    assign o_m_tvalid = r_vld[SRDB_STAGES-1];
    assign o_m_tdata  = {r_s5_z[3], r_s5_z[2], r_s5_z[1], r_s5_z[0],
                         r_s5_y[3], r_s5_y[2], r_s5_y[1], r_s5_y[0]};

endmodule

`default_nettype wire

/* hdl/srdb_chk.sv */
`default_nettype none

module srdb_chk
    import srdb_pkg::*;
#(
    parameter int OUT_W = 8 * (SAMPLE_BITS_DEF + 2)
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_s_tvalid,
    input wire logic             i_s_tready,
    input wire logic             i_m_tvalid,
    input wire logic             i_m_tready,
    input wire logic [OUT_W-1:0] i_m_tdata
);

    localparam int CNT_W = $clog2(SRDB_STAGES + 2);

    // Items accepted but not yet delivered.
    logic [CNT_W-1:0] r_cnt;
    logic             in_xfer;
    logic             out_xfer;

    assign in_xfer  = i_s_tvalid && i_s_tready;
    assign out_xfer = i_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (out_xfer && !in_xfer) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled result changed or vanished");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> r_cnt != '0)
        else $error("result without a pending item");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(SRDB_STAGES))
        else $error("more items in flight than pipeline stages");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> i_s_tready)
        else $error("empty pipeline refuses input");

endmodule

bind split_radix_dif_butterfly_top srdb_chk #(
    .OUT_W (OUT_W)
) u_srdb_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

`default_nettype wire
